[src/twn_pkg.sv]
// Shared types, constants and helpers for the text whitespace normalizer.
package twn_pkg;

  // Line length cap and derived widths
  localparam int MAX_LINE = 8192;
  localparam int LINE_W   = $clog2(MAX_LINE);
  localparam int RUN_W    = 13;
  localparam int TAB_W    = 4;
  localparam int BYTE_W   = 8;

  // Largest space count that fits the result field
  localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

  // Output queue sizing
  localparam int OQ_DEPTH = 4;
  localparam int PTR_W    = $clog2(OQ_DEPTH);
  localparam int CNT_W    = $clog2(OQ_DEPTH + 1);

  // Tab width after reset
  localparam logic [TAB_W-1:0] TAB_RESET = TAB_W'(2);

  // Request codes
  localparam logic REQ_DATA = 1'b0;
  localparam logic REQ_END  = 1'b1;

  // Character codes
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

  // One result word
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic [RUN_W-1:0]  space_run;
    logic              last;
  } res_t;

  // Results of one processed item, handed to the output queue
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  // Clamp a pending space count to the result field
  function automatic logic [RUN_W-1:0] sat_run(input logic [LINE_W-1:0] v);
    logic [LINE_W+RUN_W-1:0] ve;
    ve = (LINE_W + RUN_W)'(v);
    if (ve > (LINE_W + RUN_W)'(RUN_MAX)) begin
      return RUN_MAX;
    end
    return RUN_W'(ve);
  endfunction

endpackage

[src/twn_if.sv]
// Handshake channel interfaces for input requests and result words.
interface twn_in_if;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [twn_pkg::BYTE_W-1:0] data_byte;

  modport source (output valid, output req_type, output data_byte, input ready);
  modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

interface twn_out_if;
  logic                      valid;
  logic                      ready;
  logic [twn_pkg::BYTE_W-1:0] out_byte;
  logic [twn_pkg::RUN_W-1:0]  space_run;
  logic                      last;

  modport source (output valid, output out_byte, output space_run, output last,
                  input ready);
  modport sink   (input valid, input out_byte, input space_run, input last,
                  output ready);
endinterface

[src/text_whitespace_normalizer_unit.sv]
// Top level of the text whitespace normalizer.
//
// Input channel in_ch carries one word per request: req_type 0 with a text
// byte in data_byte, or req_type 1 to mark end of input. Output channel
// out_ch carries result words: out_byte, the count of spaces to write
// before it (space_run), and last on the final result of the request.
// A request gives zero, one or two results. The user writes tab width
// through cfg_we / cfg_wdata while the unit is idle; the block does not enforce it.
//
// A request accepted on in_ch waits in the input register; its results
// are written to the result queue, which drives out_ch.
// Throughput: one request per cycle while the queue has room. The input
// register forwards a word only while the four-entry result queue has at
// least two free entries.
// Reset (rst, synchronous) empties the input register and the queue,
// clears the line state and sets tab width to 2.
// When the receiver stalls, results wait in the queue; once it is near
// full, in_ch.ready drops until words are drained.
module text_whitespace_normalizer_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [twn_pkg::TAB_W-1:0]  cfg_wdata,
  twn_in_if.sink                     in_ch,
  twn_out_if.source                  out_ch
);

  twn_pkg::push_t push;
  logic           room;

  // Normalizing logic with its input register
  twn_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_req_type  (in_ch.req_type),
    .in_data_byte (in_ch.data_byte),
    .room         (room),
    .push         (push)
  );

  // Result queue
  twn_outq u_outq (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule

[src/twn_core.sv]
// Input register, stream state and per-item normalization logic.
module twn_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [twn_pkg::TAB_W-1:0]   cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_req_type,
  input  logic [twn_pkg::BYTE_W-1:0]  in_data_byte,
  input  logic                        room,
  output twn_pkg::push_t              push
);

  // Input register
  logic                       in_vld;
  logic                       in_req;
  logic [twn_pkg::BYTE_W-1:0] in_byte;

  // Stream state
  logic [twn_pkg::TAB_W-1:0]  tab_width;
  logic [twn_pkg::LINE_W-1:0] pending_spaces, pending_spaces_next;
  logic [twn_pkg::LINE_W-1:0] line_length, line_length_next;
  logic line_has_text, line_has_text_next;
  logic pending_blank, pending_blank_next;
  logic any_output, any_output_next;
  logic after_cr, after_cr_next;

  logic fire;
  logic [twn_pkg::LINE_W:0] len_plus_one;
  logic [twn_pkg::LINE_W:0] len_plus_tab;
  logic fits_one, fits_tab;
  twn_pkg::res_t lf_res;
  twn_pkg::push_t res;

  assign fire     = in_vld && room;
  assign in_ready = !in_vld || fire;

  // Input register: holds one word until the queue has room for its results
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ready) begin
      in_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_req  <= in_req_type;
      in_byte <= in_data_byte;
    end
  end

  // Tab width register
  always_ff @(posedge clk) begin
    if (rst) begin
      tab_width <= twn_pkg::TAB_RESET;
    end else if (cfg_we) begin
      tab_width <= cfg_wdata;
    end
  end

  // Line length cap checks
  assign len_plus_one = {1'b0, line_length} + (twn_pkg::LINE_W + 1)'(1);
  assign len_plus_tab = {1'b0, line_length} + (twn_pkg::LINE_W + 1)'(tab_width);
  assign fits_one     = len_plus_one < (twn_pkg::LINE_W + 1)'(twn_pkg::MAX_LINE);
  assign fits_tab     = len_plus_tab < (twn_pkg::LINE_W + 1)'(twn_pkg::MAX_LINE);

  assign lf_res = '{out_byte: twn_pkg::CH_LF, space_run: '0, last: 1'b1};

  // Per-item normalization
  always_comb begin
    pending_spaces_next = pending_spaces;
    line_length_next    = line_length;
    line_has_text_next  = line_has_text;
    pending_blank_next  = pending_blank;
    any_output_next     = any_output;
    after_cr_next       = after_cr;
    res                 = '0;

    if (in_req == twn_pkg::REQ_END) begin
      // end of stream: final LF if the line has text or nothing was output, then back to a fresh stream
      if (line_has_text || !any_output) begin
        res.n  = 2'd1;
        res.r0 = lf_res;
      end
      pending_spaces_next = '0;
      line_length_next    = '0;
      line_has_text_next  = 1'b0;
      pending_blank_next  = 1'b0;
      any_output_next     = 1'b0;
      after_cr_next       = 1'b0;
    end else if (in_byte == twn_pkg::CH_LF && after_cr) begin
      // LF of a CRLF pair
      after_cr_next = 1'b0;
    end else if (in_byte == twn_pkg::CH_LF || in_byte == twn_pkg::CH_CR) begin
      // line end
      if (line_has_text) begin
        res.n           = 2'd1;
        res.r0          = lf_res;
        any_output_next = 1'b1;
      end else begin
        pending_blank_next = 1'b1;
      end
      pending_spaces_next = '0;
      line_length_next    = '0;
      line_has_text_next  = 1'b0;
      after_cr_next       = (in_byte == twn_pkg::CH_CR);
    end else begin
      after_cr_next = 1'b0;
      if (in_byte == twn_pkg::CH_TAB) begin
        if (fits_tab) begin
          line_length_next    = twn_pkg::LINE_W'(len_plus_tab);
          pending_spaces_next = pending_spaces + twn_pkg::LINE_W'(tab_width);
        end
      end else if (in_byte == twn_pkg::CH_SPACE) begin
        if (fits_one) begin
          line_length_next    = twn_pkg::LINE_W'(len_plus_one);
          pending_spaces_next = pending_spaces + twn_pkg::LINE_W'(1);
        end
      end else if (in_byte != twn_pkg::CH_NUL) begin
        if (fits_one) begin
          if (!line_has_text && pending_blank) begin
            // deferred blank line goes out ahead of the text byte
            res.n              = 2'd2;
            res.r0             = lf_res;
            res.r0.last        = 1'b0;
            res.r1.out_byte    = in_byte;
            res.r1.space_run   = twn_pkg::sat_run(pending_spaces);
            res.r1.last        = 1'b1;
            pending_blank_next = 1'b0;
          end else begin
            res.n            = 2'd1;
            res.r0.out_byte  = in_byte;
            res.r0.space_run = twn_pkg::sat_run(pending_spaces);
            res.r0.last      = 1'b1;
          end
          pending_spaces_next = '0;
          line_length_next    = twn_pkg::LINE_W'(len_plus_one);
          line_has_text_next  = 1'b1;
          any_output_next     = 1'b1;
        end
      end
    end
  end

  // State update on each processed word
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_spaces <= '0;
      line_length    <= '0;
      line_has_text  <= 1'b0;
      pending_blank  <= 1'b0;
      any_output     <= 1'b0;
      after_cr       <= 1'b0;
    end else if (fire) begin
      pending_spaces <= pending_spaces_next;
      line_length    <= line_length_next;
      line_has_text  <= line_has_text_next;
      pending_blank  <= pending_blank_next;
      any_output     <= any_output_next;
      after_cr       <= after_cr_next;
    end
  end

  always_comb begin
    push = res;
    if (!fire) begin
      push.n = 2'd0;
    end
  end

  // Spaces held back never exceed the line length they were counted in
  a_pend_le_len: assert property (@(posedge clk) disable iff (rst)
    pending_spaces <= line_length)
    else $error("pending spaces exceed line length");

  // End marker leaves a fresh stream behind
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (fire && in_req == twn_pkg::REQ_END) |=>
      (pending_spaces == '0 && line_length == '0 && !line_has_text &&
       !pending_blank && !any_output && !after_cr))
    else $error("end of stream did not clear state");

  // Two results only as blank LF followed by a visible byte
  a_pair_shape: assert property (@(posedge clk) disable iff (rst)
    (push.n == 2'd2) |->
      (push.r0.out_byte == twn_pkg::CH_LF && !push.r0.last && push.r1.last &&
       push.r1.out_byte != twn_pkg::CH_LF))
    else $error("malformed result pair");

endmodule

[src/twn_outq.sv]
// Result queue between the normalizer logic and the output channel.
module twn_outq (
  input  logic                  clk,
  input  logic                  rst,
  input  twn_pkg::push_t        push,
  output logic                  room,
  twn_out_if.source             out_ch
);

  twn_pkg::res_t q [twn_pkg::OQ_DEPTH];
  logic [twn_pkg::PTR_W-1:0] wr_ptr, rd_ptr;
  logic [twn_pkg::PTR_W-1:0] wr_ptr_p1;
  logic [twn_pkg::CNT_W-1:0] count, count_next;
  logic pop;

  assign wr_ptr_p1 = wr_ptr + twn_pkg::PTR_W'(1);

  // Room for the worst case of two results per word
  assign room = count <= twn_pkg::CNT_W'(twn_pkg::OQ_DEPTH - 2);

  // Output side
  assign out_ch.valid     = count != '0;
  assign out_ch.out_byte  = q[rd_ptr].out_byte;
  assign out_ch.space_run = q[rd_ptr].space_run;
  assign out_ch.last      = q[rd_ptr].last;
  assign pop              = out_ch.valid && out_ch.ready;

  assign count_next = count + twn_pkg::CNT_W'(push.n) - twn_pkg::CNT_W'(pop);

  // Entry storage
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      q[wr_ptr] <= push.r0;
    end
    if (push.n == 2'd2) begin
      q[wr_ptr_p1] <= push.r1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + twn_pkg::PTR_W'(push.n);
      if (pop) begin
        rd_ptr <= rd_ptr + twn_pkg::PTR_W'(1);
      end
      count <= count_next;
    end
  end

  // Words are pushed only when both may fit
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push.n != 2'd0) |-> (count <= twn_pkg::CNT_W'(twn_pkg::OQ_DEPTH - 2)))
    else $error("push into a full queue");

  // Fill count matches the pointer distance
  a_cnt_ptr: assert property (@(posedge clk) disable iff (rst)
    (count != twn_pkg::CNT_W'(twn_pkg::OQ_DEPTH)) |->
      (twn_pkg::PTR_W'(count) == twn_pkg::PTR_W'(wr_ptr - rd_ptr)))
    else $error("queue count out of step with pointers");

  // Fill count never passes the queue depth
  a_cnt_max: assert property (@(posedge clk) disable iff (rst)
    count <= twn_pkg::CNT_W'(twn_pkg::OQ_DEPTH))
    else $error("queue count above depth");

endmodule
